// ===== rtl/gcs_pkg.sv =====
// ----------------------------------------------------------------------------
// gcs_pkg
// shared widths, message kinds, register indexes and structs of the
// group closure handshake node
// ----------------------------------------------------------------------------
package gcs_pkg;

	localparam int MAX_NODES_DEF = 64;
	localparam int RESULT_LIMIT  = 64;

	localparam int SENDS_W = 10;
	localparam int KIND_W  = 3;
	localparam int RANK_W  = 6;
	localparam int SIZE_W  = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// message kinds
	localparam logic [KIND_W-1:0] K_CLOSURE  = 3'd0;
	localparam logic [KIND_W-1:0] K_APPROVE  = 3'd1;
	localparam logic [KIND_W-1:0] K_REJECT   = 3'd2;
	localparam logic [KIND_W-1:0] K_TRY      = 3'd3;
	localparam logic [KIND_W-1:0] K_FORCE    = 3'd4;
	localparam logic [KIND_W-1:0] K_WITHDRAW = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MASTER_EN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MASTER_RANK = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_RANK    = 2'd3;

	typedef struct packed {
		logic [SIZE_W-1:0] group_size;
		logic              master_en;
		logic [RANK_W-1:0] master_rank;
		logic [RANK_W-1:0] own_rank;
	} cfg_t;

	// one run of results caused by an accepted item
	typedef struct packed {
		logic [SIZE_W-1:0] count;
		logic              bcast;
		logic              send_valid;
		logic              closed;
		logic [KIND_W-1:0] kind;
		logic [RANK_W-1:0] dest;
		logic [RANK_W-1:0] sender;
	} job_t;

endpackage

// ===== rtl/gcs_in_if.sv =====
// ----------------------------------------------------------------------------
// gcs_in_if
// input channel: poll items and received locking messages
// ----------------------------------------------------------------------------
interface gcs_in_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [gcs_pkg::SENDS_W-1:0] active_sends;
	logic [gcs_pkg::KIND_W-1:0]  msg_kind;

	modport source (output valid, output mode, output active_sends, output msg_kind,
		input ready);
	modport sink (input valid, input mode, input active_sends, input msg_kind,
		output ready);
endinterface

// ===== rtl/gcs_out_if.sv =====
// ----------------------------------------------------------------------------
// gcs_out_if
// result channel: messages to send and closed reports
// ----------------------------------------------------------------------------
interface gcs_out_if;
	logic                       valid;
	logic                       ready;
	logic                       send_valid;
	logic [gcs_pkg::RANK_W-1:0] dest;
	logic [gcs_pkg::RANK_W-1:0] sender;
	logic [gcs_pkg::KIND_W-1:0] out_kind;
	logic                       closed;
	logic                       last;

	modport source (output valid, output send_valid, output dest, output sender,
		output out_kind, output closed, output last, input ready);
	modport sink (input valid, input send_valid, input dest, input sender,
		input out_kind, input closed, input last, output ready);
endinterface

// ===== rtl/gcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcs_ctrl
// node state and master counters; turns one accepted item into a run of
// results and updates the state at the transfer
// ----------------------------------------------------------------------------
module gcs_ctrl #(
	parameter int MAX_NODES = gcs_pkg::MAX_NODES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gcs_pkg::cfg_t               cfg,
	input  logic                        accept,
	input  logic                        mode,
	input  logic [gcs_pkg::SENDS_W-1:0] active_sends,
	input  logic [gcs_pkg::KIND_W-1:0]  msg_kind,
	output gcs_pkg::job_t               job
);

	typedef enum logic [1:0] {ST_OPEN, ST_LOOSE, ST_CLOSURE, ST_CLOSED} node_state_t;

	localparam logic [gcs_pkg::SIZE_W-1:0] BCAST_MAX = gcs_pkg::SIZE_W'(
		(MAX_NODES < gcs_pkg::RESULT_LIMIT) ? MAX_NODES : gcs_pkg::RESULT_LIMIT);

	node_state_t                  state_q, state_d;
	logic [gcs_pkg::SIZE_W-1:0]   close_q, close_d;
	logic [gcs_pkg::SIZE_W-1:0]   approve_q, approve_d;
	logic [gcs_pkg::SIZE_W-1:0]   close_dn, approve_dn, bcast_n;

	assign close_dn   = (close_q != '0) ? close_q - 1'b1 : '0;
	assign approve_dn = (approve_q != '0) ? approve_q - 1'b1 : '0;
	assign bcast_n    = (cfg.group_size < BCAST_MAX) ? cfg.group_size : BCAST_MAX;

	always_comb begin
		state_d   = state_q;
		close_d   = close_q;
		approve_d = approve_q;
		job       = '0;
		if (!mode) begin
			unique case (state_q)
				ST_OPEN: begin
					if (active_sends == '0) begin
						job.count      = gcs_pkg::SIZE_W'(1);
						job.send_valid = 1'b1;
						job.kind       = gcs_pkg::K_CLOSURE;
						state_d        = ST_LOOSE;
					end
				end
				ST_CLOSURE: begin
					job.count      = gcs_pkg::SIZE_W'(1);
					job.send_valid = 1'b1;
					if (active_sends == '0) begin
						job.kind = gcs_pkg::K_APPROVE;
						state_d  = ST_LOOSE;
					end else begin
						job.kind = gcs_pkg::K_REJECT;
						state_d  = ST_OPEN;
					end
				end
				ST_CLOSED: begin
					job.count  = gcs_pkg::SIZE_W'(1);
					job.closed = 1'b1;
					state_d    = ST_OPEN;
				end
				ST_LOOSE: begin
				end
				default: begin
				end
			endcase
			if (job.send_valid) begin
				job.dest   = cfg.master_rank;
				job.sender = cfg.own_rank;
			end
		end else begin
			if (cfg.master_en) begin
				unique case (msg_kind)
					gcs_pkg::K_CLOSURE: begin
						close_d = close_dn;
						if (close_dn == '0) begin
							job.bcast = 1'b1;
							job.kind  = gcs_pkg::K_TRY;
							approve_d = cfg.group_size;
						end
					end
					gcs_pkg::K_APPROVE: begin
						approve_d = approve_dn;
						if (approve_dn == '0) begin
							job.bcast = 1'b1;
							job.kind  = gcs_pkg::K_FORCE;
							close_d   = cfg.group_size;
						end
					end
					gcs_pkg::K_REJECT: begin
						job.bcast = 1'b1;
						job.kind  = gcs_pkg::K_WITHDRAW;
						close_d   = cfg.group_size;
					end
					default: begin
					end
				endcase
				if (job.bcast) begin
					job.count      = bcast_n;
					job.send_valid = 1'b1;
					job.sender     = cfg.own_rank;
				end
			end
			unique case (msg_kind)
				gcs_pkg::K_TRY:      state_d = ST_CLOSURE;
				gcs_pkg::K_FORCE:    state_d = ST_CLOSED;
				gcs_pkg::K_WITHDRAW: state_d = ST_OPEN;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_OPEN;
			close_q   <= gcs_pkg::SIZE_W'(1);
			approve_q <= gcs_pkg::SIZE_W'(1);
		end else if (accept) begin
			state_q   <= state_d;
			close_q   <= close_d;
			approve_q <= approve_d;
		end
	end

	// a broadcast always reloads one of the counters
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && job.bcast |=> close_q == $past(cfg.group_size)
			|| approve_q == $past(cfg.group_size))
		else $error("broadcast without counter reload");

	// a single reply always goes to the master
	assert property (@(posedge clk) disable iff (!arst_n)
		!mode && job.send_valid |-> job.dest == cfg.master_rank && !job.bcast)
		else $error("reply not addressed to master");

	// only a poll reports closed
	assert property (@(posedge clk) disable iff (!arst_n)
		job.closed |-> !mode && !job.send_valid && state_d == ST_OPEN)
		else $error("closed report out of place");

endmodule

// ===== rtl/gcs_burst.sv =====
// ----------------------------------------------------------------------------
// gcs_burst
// result register; plays out a run of results one per transfer, counting
// the destination rank up through a broadcast
// ----------------------------------------------------------------------------
module gcs_burst (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  gcs_pkg::job_t job,
	output logic          can_load,
	gcs_out_if.source     out_ch
);

	logic                        busy_q;
	logic                        bcast_s1;
	logic                        send_valid_s1;
	logic                        closed_s1;
	logic                        last_s1;
	logic [gcs_pkg::KIND_W-1:0]  kind_s1;
	logic [gcs_pkg::RANK_W-1:0]  dest_s1;
	logic [gcs_pkg::RANK_W-1:0]  sender_s1;
	logic [gcs_pkg::SIZE_W-1:0]  count_s1;
	logic                        take;

	assign take     = out_ch.valid && out_ch.ready;
	assign can_load = !busy_q || (out_ch.ready && last_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (take && last_s1) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bcast_s1      <= job.bcast;
			send_valid_s1 <= job.send_valid;
			closed_s1     <= job.closed;
			kind_s1       <= job.kind;
			sender_s1     <= job.sender;
			count_s1      <= job.count;
			dest_s1       <= job.bcast ? '0 : job.dest;
			last_s1       <= (job.count == gcs_pkg::SIZE_W'(1));
		end else if (take && !last_s1) begin
			dest_s1 <= dest_s1 + 1'b1;
			last_s1 <= ({1'b0, dest_s1} + gcs_pkg::SIZE_W'(2)) == count_s1;
		end
	end

	assign out_ch.valid      = busy_q;
	assign out_ch.send_valid = send_valid_s1;
	assign out_ch.dest       = dest_s1;
	assign out_ch.sender     = sender_s1;
	assign out_ch.out_kind   = kind_s1;
	assign out_ch.closed     = closed_s1;
	assign out_ch.last       = last_s1;

	// a run does not end before its last result
	assert property (@(posedge clk) disable iff (!arst_n)
		take && !last_s1 |=> out_ch.valid)
		else $error("run ended early");

	// broadcast ranks count up by one
	assert property (@(posedge clk) disable iff (!arst_n)
		take && !last_s1 |=> bcast_s1 && dest_s1 == $past(dest_s1) + 1'b1)
		else $error("broadcast rank skipped");

	// a closed report is a lone result with no message
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.closed |-> out_ch.last && !out_ch.send_valid
			&& out_ch.dest == '0 && out_ch.sender == '0)
		else $error("bad closed report");

endmodule

// ===== rtl/group_closure_handshake.sv =====
// ----------------------------------------------------------------------------
// group_closure_handshake
// one node of a two-phase closure handshake across a group
// ----------------------------------------------------------------------------
// An item's state update is done at its input transfer. A poll gives at most
// one result; a master reject or a master message that ends a count gives a
// broadcast of min(group_size, MAX_NODES, 64) results, one per output
// transfer, counted out by the result register. The input is ready whenever
// the result register is empty or its last result is being taken, so items
// stream at one per cycle while the output takes each result; a broadcast
// holds the input until its last result is taken. Items that give no result
// still wait for that slot. Configuration writes do not reload the counters.
// ----------------------------------------------------------------------------
module group_closure_handshake #(
	parameter int MAX_NODES = gcs_pkg::MAX_NODES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gcs_pkg::CFG_DATA_W-1:0] cfg_data,
	gcs_in_if.sink                         in_ch,
	gcs_out_if.source                      out_ch
);

	gcs_pkg::cfg_t cfg_q;
	gcs_pkg::job_t job;
	logic          can_load;
	logic          accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.group_size  <= gcs_pkg::SIZE_W'(1);
			cfg_q.master_en   <= 1'b0;
			cfg_q.master_rank <= '0;
			cfg_q.own_rank    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gcs_pkg::CFG_GROUP_SIZE:  cfg_q.group_size  <= cfg_data;
				gcs_pkg::CFG_MASTER_EN:   cfg_q.master_en   <= cfg_data[0];
				gcs_pkg::CFG_MASTER_RANK: cfg_q.master_rank <= cfg_data[gcs_pkg::RANK_W-1:0];
				gcs_pkg::CFG_OWN_RANK:    cfg_q.own_rank    <= cfg_data[gcs_pkg::RANK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_ch.ready = can_load;
	assign accept      = in_ch.valid && can_load;

	gcs_ctrl #(
		.MAX_NODES(MAX_NODES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.accept       (accept),
		.mode         (in_ch.mode),
		.active_sends (in_ch.active_sends),
		.msg_kind     (in_ch.msg_kind),
		.job          (job)
	);

	gcs_burst u_burst (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept && (job.count != '0)),
		.job      (job),
		.can_load (can_load),
		.out_ch   (out_ch)
	);

endmodule

// ===== verif/group_closure_handshake_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_closure_handshake_tb
// Drives poll items and locking messages into one handshake node and checks
// every result against an in-bench model of the node state, the master
// counters and the broadcasts. Directed tests cover the node replies, the
// master counting, the broadcast length and backpressure. A random part
// then runs handshake rounds with random content and noise, using random
// idling on both channels.
// ----------------------------------------------------------------------------
module group_closure_handshake_tb;

	localparam int KIND_W     = gcs_pkg::KIND_W;
	localparam int SENDS_W    = gcs_pkg::SENDS_W;
	localparam int RANK_W     = gcs_pkg::RANK_W;
	localparam int SIZE_W     = gcs_pkg::SIZE_W;
	localparam int CFG_IDX_W  = gcs_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = gcs_pkg::CFG_DATA_W;

	localparam logic MODE_POLL = 1'b0;
	localparam logic MODE_MSG  = 1'b1;
	localparam logic [KIND_W-1:0] K_SPARE6  = 3'd6;
	localparam logic [KIND_W-1:0] K_SPARE7  = 3'd7;
	localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;
	localparam int RANDOM_ITEMS = 300;
	localparam int BIG_ROUND_ITEMS = 150;
	localparam int SETTLE_CYCLES = 4;

	typedef enum logic [1:0] {NS_OPEN, NS_LOOSE, NS_CLOSURE, NS_CLOSED} node_state_t;

	typedef struct packed {
		logic               mode;
		logic [SENDS_W-1:0] active_sends;
		logic [KIND_W-1:0]  msg_kind;
	} gcs_item_t;

	typedef struct packed {
		logic              send_valid;
		logic [RANK_W-1:0] dest;
		logic [RANK_W-1:0] sender;
		logic [KIND_W-1:0] out_kind;
		logic              closed;
		logic              last;
	} gcs_msg_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gcs_in_if in_ch ();
	gcs_out_if out_ch ();

	group_closure_handshake i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// node model
	logic [SIZE_W-1:0] grp_size    = 7'd1;
	logic              grp_master  = 1'b0;
	logic [RANK_W-1:0] master_id   = '0;
	logic [RANK_W-1:0] own_id      = '0;
	node_state_t       node_st     = NS_OPEN;
	logic [SIZE_W-1:0] close_left  = 7'd1;
	logic [SIZE_W-1:0] approve_left = 7'd1;

	gcs_msg_t pending_msgs[$];
	int mismatch_cnt = 0;
	int sent_items = 0;
	int src_gap_max = 8;
	int snk_gap_max = 8;
	int hold_cycles = 0;
	gcs_msg_t got_msg;
	gcs_msg_t want_msg;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic void push_msg(logic valid, logic [RANK_W-1:0] dest,
		logic [KIND_W-1:0] kind, logic closed, logic last);
		gcs_msg_t m;
		m.send_valid = valid;
		m.dest       = dest;
		m.sender     = valid ? own_id : '0;
		m.out_kind   = kind;
		m.closed     = closed;
		m.last       = last;
		pending_msgs.insert(pending_msgs.size(), m);
	endfunction

	function automatic void push_broadcast(logic [KIND_W-1:0] kind);
		int n;
		n = grp_size;
		if (n > gcs_pkg::MAX_NODES_DEF)
			n = gcs_pkg::MAX_NODES_DEF;
		if (n > gcs_pkg::RESULT_LIMIT)
			n = gcs_pkg::RESULT_LIMIT;
		for (int i = 0; i < n; i++)
			push_msg(1'b1, RANK_W'(i), kind, 1'b0, i == n - 1);
	endfunction

	function automatic void advance_node(gcs_item_t it);
		if (it.mode == MODE_POLL) begin
			case (node_st)
				NS_OPEN: begin
					if (it.active_sends == 0) begin
						push_msg(1'b1, master_id, gcs_pkg::K_CLOSURE, 1'b0, 1'b1);
						node_st = NS_LOOSE;
					end
				end
				NS_CLOSURE: begin
					if (it.active_sends == 0) begin
						push_msg(1'b1, master_id, gcs_pkg::K_APPROVE, 1'b0, 1'b1);
						node_st = NS_LOOSE;
					end else begin
						push_msg(1'b1, master_id, gcs_pkg::K_REJECT, 1'b0, 1'b1);
						node_st = NS_OPEN;
					end
				end
				NS_CLOSED: begin
					push_msg(1'b0, '0, KIND_NONE, 1'b1, 1'b1);
					node_st = NS_OPEN;
				end
				default: ;
			endcase
			return;
		end
		if (grp_master) begin
			case (it.msg_kind)
				gcs_pkg::K_CLOSURE: begin
					if (close_left != 0)
						close_left = close_left - 1'b1;
					if (close_left == 0) begin
						push_broadcast(gcs_pkg::K_TRY);
						approve_left = grp_size;
					end
				end
				gcs_pkg::K_APPROVE: begin
					if (approve_left != 0)
						approve_left = approve_left - 1'b1;
					if (approve_left == 0) begin
						push_broadcast(gcs_pkg::K_FORCE);
						close_left = grp_size;
					end
				end
				gcs_pkg::K_REJECT: begin
					push_broadcast(gcs_pkg::K_WITHDRAW);
					close_left = grp_size;
				end
				default: ;
			endcase
		end
		case (it.msg_kind)
			gcs_pkg::K_TRY:      node_st = NS_CLOSURE;
			gcs_pkg::K_FORCE:    node_st = NS_CLOSED;
			gcs_pkg::K_WITHDRAW: node_st = NS_OPEN;
			default: ;
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got_msg = '{out_ch.send_valid, out_ch.dest, out_ch.sender, out_ch.out_kind,
				out_ch.closed, out_ch.last};
			if (pending_msgs.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: unexpected result sv=%0d dest=%0d snd=%0d kind=%0d cl=%0d last=%0d",
						$realtime, got_msg.send_valid, got_msg.dest, got_msg.sender,
						got_msg.out_kind, got_msg.closed, got_msg.last);
			end else begin
				want_msg = pending_msgs.pop_front();
				if (got_msg.send_valid !== want_msg.send_valid || got_msg.dest !== want_msg.dest
					|| got_msg.sender !== want_msg.sender
					|| got_msg.out_kind !== want_msg.out_kind
					|| got_msg.closed !== want_msg.closed || got_msg.last !== want_msg.last) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$display("%0t: mismatch exp sv=%0d dest=%0d snd=%0d kind=%0d cl=%0d last=%0d",
							$realtime, want_msg.send_valid, want_msg.dest, want_msg.sender,
							want_msg.out_kind, want_msg.closed, want_msg.last);
						$display("%0t:          got sv=%0d dest=%0d snd=%0d kind=%0d cl=%0d last=%0d",
							$realtime, got_msg.send_valid, got_msg.dest, got_msg.sender,
							got_msg.out_kind, got_msg.closed, got_msg.last);
					end
				end
			end
		end
	end

	// result receiver with random stalls and long hold-offs
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, snk_gap_max) + hold_cycles;
			hold_cycles = 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid)
				@(posedge clk);
		end
	end

	task automatic send_item(gcs_item_t it);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.mode         <= it.mode;
		in_ch.active_sends <= it.active_sends;
		in_ch.msg_kind     <= it.msg_kind;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		advance_node(it);
		sent_items++;
	endtask

	task automatic send_poll(logic [SENDS_W-1:0] sends);
		send_item('{MODE_POLL, sends, KIND_W'($urandom_range(0, 7))});
	endtask

	task automatic send_msg(logic [KIND_W-1:0] kind);
		send_item('{MODE_MSG, SENDS_W'($urandom_range(0, 1023)), kind});
	endtask

	function automatic gcs_item_t noise_item();
		gcs_item_t it;
		it.mode = 1'($urandom_range(0, 1));
		it.active_sends = $urandom_range(0, 1) ? '0 : SENDS_W'($urandom_range(0, 1023));
		it.msg_kind = KIND_W'($urandom_range(0, 7));
		return it;
	endfunction

	// wait until every expected transfer has come and the block is quiet
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending_msgs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(int gs, bit master, int mrank, int orank);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= gcs_pkg::CFG_GROUP_SIZE;
		cfg_data  <= CFG_DATA_W'(gs);
		@(posedge clk);
		grp_size = SIZE_W'(gs);
		cfg_index <= gcs_pkg::CFG_MASTER_EN;
		cfg_data  <= CFG_DATA_W'(master);
		@(posedge clk);
		grp_master = master;
		cfg_index <= gcs_pkg::CFG_MASTER_RANK;
		cfg_data  <= CFG_DATA_W'(mrank);
		@(posedge clk);
		master_id = RANK_W'(mrank);
		cfg_index <= gcs_pkg::CFG_OWN_RANK;
		cfg_data  <= CFG_DATA_W'(orank);
		@(posedge clk);
		own_id = RANK_W'(orank);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_node_replies();
		load_config(1, 1'b0, 63, 0);
		send_poll(10'd1023);
		send_poll(10'd0);
		send_poll(10'd0);
		send_msg(gcs_pkg::K_CLOSURE);
		send_msg(gcs_pkg::K_APPROVE);
		send_msg(gcs_pkg::K_REJECT);
		send_msg(K_SPARE6);
		send_msg(K_SPARE7);
		send_msg(gcs_pkg::K_TRY);
		send_poll(10'd512);
		send_msg(gcs_pkg::K_TRY);
		send_poll(10'd0);
		send_msg(gcs_pkg::K_FORCE);
		send_poll(10'd1023);
		send_msg(gcs_pkg::K_FORCE);
		send_msg(gcs_pkg::K_WITHDRAW);
	endtask

	task automatic test_master_counting();
		load_config(3, 1'b1, 0, 63);
		send_msg(gcs_pkg::K_CLOSURE);
		send_msg(gcs_pkg::K_CLOSURE);
		repeat (3) send_msg(gcs_pkg::K_APPROVE);
		send_msg(gcs_pkg::K_APPROVE);
		send_msg(gcs_pkg::K_REJECT);
	endtask

	task automatic test_broadcast_length();
		load_config(0, 1'b1, 5, 17);
		send_msg(gcs_pkg::K_REJECT);
		send_msg(gcs_pkg::K_CLOSURE);
		load_config(64, 1'b1, 5, 17);
		send_msg(gcs_pkg::K_REJECT);
		load_config(100, 1'b1, 42, 21);
		send_msg(gcs_pkg::K_REJECT);
	endtask

	task automatic test_backpressure();
		load_config(4, 1'b1, 9, 33);
		src_gap_max = 0;
		hold_cycles = 200;
		repeat (6) begin
			send_msg(gcs_pkg::K_REJECT);
			send_poll(10'd0);
			send_msg(gcs_pkg::K_WITHDRAW);
		end
		src_gap_max = 8;
		settle();
	endtask

	task automatic run_round();
		int reps;
		bit approve;
		send_poll(($urandom_range(0, 3) == 0) ? SENDS_W'($urandom_range(1, 1023)) : '0);
		if (grp_master) begin
			reps = (close_left == 0) ? 1 : close_left;
			repeat (reps) begin
				send_msg(gcs_pkg::K_CLOSURE);
				if ($urandom_range(0, 15) == 0)
					send_item(noise_item());
			end
		end
		send_msg(gcs_pkg::K_TRY);
		approve = $urandom_range(0, 3) != 0;
		send_poll(approve ? '0 : SENDS_W'($urandom_range(1, 1023)));
		if (approve) begin
			if (grp_master) begin
				reps = (approve_left == 0) ? 1 : approve_left;
				repeat (reps) begin
					send_msg(gcs_pkg::K_APPROVE);
					if ($urandom_range(0, 15) == 0)
						send_item(noise_item());
				end
			end
			send_msg(gcs_pkg::K_FORCE);
			send_poll(SENDS_W'($urandom_range(0, 1023)));
		end else begin
			if (grp_master)
				send_msg(gcs_pkg::K_REJECT);
			send_msg(gcs_pkg::K_WITHDRAW);
		end
	endtask

	task automatic test_random_rounds();
		int stop_at;
		int gs;
		stop_at = sent_items + RANDOM_ITEMS;
		while (sent_items < stop_at) begin
			if ((stop_at - sent_items > BIG_ROUND_ITEMS) && ($urandom_range(0, 7) == 0))
				gs = 64;
			else
				gs = $urandom_range(1, 6);
			load_config(gs, $urandom_range(0, 3) != 0, $urandom_range(0, 63),
				$urandom_range(0, 63));
			src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
			snk_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
			repeat (6) begin
				if (sent_items < stop_at) begin
					if ($urandom_range(0, 9) < 7)
						run_round();
					else
						repeat ($urandom_range(2, 8)) send_item(noise_item());
				end
			end
		end
		snk_gap_max = 8;
	endtask

	initial begin
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= gcs_pkg::CFG_GROUP_SIZE;
		cfg_data           <= '0;
		in_ch.valid        <= 1'b0;
		in_ch.mode         <= MODE_POLL;
		in_ch.active_sends <= '0;
		in_ch.msg_kind     <= gcs_pkg::K_CLOSURE;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_node_replies();
		test_master_counting();
		test_broadcast_length();
		test_backpressure();
		test_random_rounds();
		settle();
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
